@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check on every clock edge outside reset
`define ASH_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// same-cycle implication
`define ASH_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASH_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/ash_pkg.sv @@
package ash_pkg;

  localparam logic [2:0] FN_INSERT   = 3'd0;
  localparam logic [2:0] FN_READ     = 3'd1;
  localparam logic [2:0] FN_CLEAR    = 3'd2;
  localparam logic [2:0] FN_COLLAPSE = 3'd3;
  localparam logic [2:0] FN_RESTART  = 3'd4;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_FULL   = 2'd1;
  localparam logic [1:0] STS_RANGE  = 2'd2;

  localparam logic [1:0] REG_LOW  = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_MINW = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] sample;
    logic [5:0]         bar_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         bin_index;
    logic signed [31:0] bar_start;
    logic signed [31:0] bar_end;
    logic [31:0]        bar_count;
    logic [6:0]         bar_total;
    logic [31:0]        sample_total;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_INIT0, ST_INIT1, ST_IDLE,
    ST_INS_R0, ST_INS_RN, ST_INS_CHK, ST_SRCH_ISS, ST_SRCH_CMP,
    ST_LO_RD, ST_LO_NL, ST_HI_RD, ST_HI_WR, ST_SHIFT, ST_LO_WR,
    ST_CNT_RD, ST_CNT_RD1, ST_CNT_UPD, ST_CNT_SQ, ST_SPL_DEC,
    ST_MUL0, ST_MUL1, ST_DIV_GO, ST_DIV, ST_SPL_WR0, ST_SPL_WR1,
    ST_RB_RD, ST_RB_RD1, ST_RB_END, ST_CLR, ST_COL_RD, ST_COL_WR, ST_OUT
  } state_t;

endpackage

@@ rtl/core/ash_div.sv @@
module ash_div #(
  parameter int NUM_W = 81,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic             rem_nz
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_r;
  logic             run_r;
  logic             done_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        cnt_r  <= '0;
        num_r  <= num;
        rem_r  <= '0;
        quot_r <= '0;
      end else if (run_r) begin
        num_r  <= num_r << 1;
        quot_r <= {quot_r[NUM_W-2:0], fits};
        rem_r  <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        if (cnt_r == CW'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
    end
  end

  assign done   = done_r;
  assign quot   = quot_r;
  assign rem_nz = rem_r != '0;

endmodule

@@ rtl/core/adaptive_streaming_histogram_core.sv @@
// insert: binary search over the edges, each probe issuing an edge read, then a compare
// clear zeroes the count of every bin in use; a bin grown at the low end moves all edges,
// one grown at the high end moves none; a split moves the edges above the bin up a place
// and then runs the serial mean division
// one item at a time: the next item is taken once the result sits in the output register
// reset: control clears, then the edges are set up from the configuration with the input stalled
module adaptive_streaming_histogram_core #(
  parameter int MAX_BINS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ash_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ash_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int W   = VALUE_BITS;
  localparam int XW  = ((W > 32) ? W : 32) + 2;   // headroom for sums
  localparam int NW  = $clog2(MAX_BINS + 1);      // bin count and edge address
  localparam int CAW = $clog2(MAX_BINS);          // count address
  localparam int DW  = W + 1;                     // edge difference
  localparam int PW  = DW + 32;                   // product for the mean
  localparam logic signed [XW-1:0] VMAX = signed'((XW'(1) << (W - 1)) - XW'(1));
  localparam logic signed [XW-1:0] VMIN = -VMAX - XW'(1);

  function automatic logic signed [W-1:0] clampv(input logic signed [XW-1:0] v);
    if (v > VMAX) clampv = VMAX[W-1:0];
    else if (v < VMIN) clampv = VMIN[W-1:0];
    else clampv = v[W-1:0];
  endfunction

  function automatic logic [31:0] to32(input logic signed [W-1:0] e);
    logic signed [XW-1:0] x;
    x = XW'(e);
    return x[31:0];
  endfunction

  // configuration
  logic signed [31:0] low_r, high_r;
  logic [30:0]        minw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= 32'sd0;
      high_r <= 32'sd65536;
      minw_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ash_pkg::REG_LOW:  low_r  <= cfg_data;
        ash_pkg::REG_HIGH: high_r <= cfg_data;
        ash_pkg::REG_MINW: minw_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // table memories: edges and counts, one write and one registered read each
  logic signed [W-1:0] edge_mem [0:MAX_BINS];
  logic [31:0]         cnt_mem  [0:MAX_BINS-1];
  logic                edge_we, cnt_we;
  logic [NW-1:0]       edge_wa, edge_ra;
  logic [CAW-1:0]      cnt_wa, cnt_ra;
  logic signed [W-1:0] edge_wd, edge_rd;
  logic [31:0]         cnt_wd, cnt_rd;

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_rd <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_ra];
  end

  // control and datapath state
  ash_pkg::state_t     state_r, state_nxt;
  logic                quiet_r;
  logic signed [W-1:0] s_r, e0_r, en_r, bs_r, be_r, nl_r;
  logic [5:0]          k_r, idx_r;
  logic [NW-1:0]       n_r, a_r, z_r, pos_r, clr_i_r;
  logic [31:0]         samples_r, cnt_r;
  logic [1:0]          status_r;
  logic [63:0]         sq_r;
  logic [NW-1:0]       sh_i_r, sh_prev_r, sh_base_r;
  logic                sh_pend_r, sh_fin_r, grow_r;
  logic [DW-1:0]       diff_r;
  logic [PW-1:0]       acc_r;
  logic                out_valid_r;
  ash_pkg::out_item_t  out_r;

  logic                accept, out_free;
  logic [NW-1:0]       mid;
  logic                lo_out, hi_out, rd_ok, do_split;
  logic signed [XW-1:0] width_x;
  logic [31:0]         up_c, dn_c, cnt_inc;
  logic [63:0]         diff64;
  logic                div_start, div_done, div_rem_nz;
  logic [PW-1:0]       div_q;
  logic signed [W+1:0] mean_x;
  logic signed [W-1:0] mean;

  assign accept   = (state_r == ash_pkg::ST_IDLE) && in_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign mid      = NW'(((NW + 1)'(a_r) + (NW + 1)'(z_r)) >> 1);
  assign lo_out   = s_r < e0_r;
  assign hi_out   = s_r >= edge_rd;
  assign rd_ok    = 32'(in_data.bar_index) < 32'(n_r);
  assign width_x  = XW'(be_r) - XW'(bs_r);
  assign do_split = (n_r < NW'(MAX_BINS)) && (sq_r > {32'd0, samples_r})
                    && (width_x > signed'(XW'(minw_r)));
  assign up_c     = cnt_r >> 1;
  assign dn_c     = cnt_r - up_c;
  assign cnt_inc  = (cnt_r == 32'hFFFF_FFFF) ? cnt_r : cnt_r + 32'd1;
  assign diff64   = 64'(diff_r);
  // count-weighted mean, nudged toward zero when negative and inexact
  assign mean_x   = (W + 2)'(bs_r) + signed'((W + 2)'(div_q[DW-1:0]))
                    + (W + 2)'(((W + 2)'(bs_r) + signed'((W + 2)'(div_q[DW-1:0])) < 0)
                    && div_rem_nz);
  assign mean     = mean_x[W-1:0];

  ash_div #(.NUM_W(PW), .DEN_W(32)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (acc_r),
    .den    (cnt_r),
    .done   (div_done),
    .quot   (div_q),
    .rem_nz (div_rem_nz)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ash_pkg::ST_INIT0: state_nxt = ash_pkg::ST_INIT1;
      ash_pkg::ST_INIT1: state_nxt = quiet_r ? ash_pkg::ST_IDLE : ash_pkg::ST_OUT;
      ash_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            ash_pkg::FN_INSERT:   state_nxt = ash_pkg::ST_INS_R0;
            ash_pkg::FN_READ:     state_nxt = rd_ok ? ash_pkg::ST_RB_RD : ash_pkg::ST_OUT;
            ash_pkg::FN_CLEAR:    state_nxt = ash_pkg::ST_CLR;
            ash_pkg::FN_COLLAPSE: state_nxt = ash_pkg::ST_COL_RD;
            ash_pkg::FN_RESTART:  state_nxt = ash_pkg::ST_INIT0;
            default:              state_nxt = ash_pkg::ST_OUT;
          endcase
        end
      end
      ash_pkg::ST_INS_R0: state_nxt = ash_pkg::ST_INS_RN;
      ash_pkg::ST_INS_RN: state_nxt = ash_pkg::ST_INS_CHK;
      ash_pkg::ST_INS_CHK: begin
        if (lo_out || hi_out) begin
          if (n_r == NW'(MAX_BINS)) state_nxt = ash_pkg::ST_OUT;
          else if (lo_out) state_nxt = ash_pkg::ST_LO_RD;
          else state_nxt = ash_pkg::ST_HI_RD;
        end else begin
          state_nxt = ash_pkg::ST_SRCH_ISS;
        end
      end
      ash_pkg::ST_SRCH_ISS:
        state_nxt = (z_r - a_r > NW'(1)) ? ash_pkg::ST_SRCH_CMP : ash_pkg::ST_CNT_RD;
      ash_pkg::ST_SRCH_CMP: state_nxt = ash_pkg::ST_SRCH_ISS;
      ash_pkg::ST_LO_RD:    state_nxt = ash_pkg::ST_LO_NL;
      ash_pkg::ST_LO_NL:    state_nxt = ash_pkg::ST_SHIFT;
      ash_pkg::ST_HI_RD:    state_nxt = ash_pkg::ST_HI_WR;
      ash_pkg::ST_HI_WR:    state_nxt = ash_pkg::ST_CNT_RD;
      ash_pkg::ST_SHIFT: begin
        if (sh_fin_r) state_nxt = grow_r ? ash_pkg::ST_LO_WR : ash_pkg::ST_MUL0;
      end
      ash_pkg::ST_LO_WR:    state_nxt = ash_pkg::ST_CNT_RD;
      ash_pkg::ST_CNT_RD:   state_nxt = ash_pkg::ST_CNT_RD1;
      ash_pkg::ST_CNT_RD1:  state_nxt = ash_pkg::ST_CNT_UPD;
      ash_pkg::ST_CNT_UPD:  state_nxt = ash_pkg::ST_CNT_SQ;
      ash_pkg::ST_CNT_SQ:   state_nxt = ash_pkg::ST_SPL_DEC;
      ash_pkg::ST_SPL_DEC:  state_nxt = do_split ? ash_pkg::ST_SHIFT : ash_pkg::ST_OUT;
      ash_pkg::ST_MUL0:     state_nxt = ash_pkg::ST_MUL1;
      ash_pkg::ST_MUL1:     state_nxt = ash_pkg::ST_DIV_GO;
      ash_pkg::ST_DIV_GO:   state_nxt = ash_pkg::ST_DIV;
      ash_pkg::ST_DIV:      if (div_done) state_nxt = ash_pkg::ST_SPL_WR0;
      ash_pkg::ST_SPL_WR0:  state_nxt = ash_pkg::ST_SPL_WR1;
      ash_pkg::ST_SPL_WR1:  state_nxt = ash_pkg::ST_OUT;
      ash_pkg::ST_RB_RD:    state_nxt = ash_pkg::ST_RB_RD1;
      ash_pkg::ST_RB_RD1:   state_nxt = ash_pkg::ST_RB_END;
      ash_pkg::ST_RB_END:   state_nxt = ash_pkg::ST_OUT;
      ash_pkg::ST_CLR: if (clr_i_r == n_r - NW'(1)) state_nxt = ash_pkg::ST_OUT;
      ash_pkg::ST_COL_RD:   state_nxt = ash_pkg::ST_COL_WR;
      ash_pkg::ST_COL_WR:   state_nxt = ash_pkg::ST_OUT;
      ash_pkg::ST_OUT:      if (out_free) state_nxt = ash_pkg::ST_IDLE;
      default:              state_nxt = ash_pkg::ST_IDLE;
    endcase
  end

  // memory ports and strobes
  always_comb begin
    in_stall  = state_r != ash_pkg::ST_IDLE;
    div_start = 1'b0;
    edge_we   = 1'b0;
    edge_wa   = '0;
    edge_wd   = '0;
    edge_ra   = '0;
    cnt_we    = 1'b0;
    cnt_wa    = '0;
    cnt_wd    = '0;
    cnt_ra    = '0;
    case (state_r)
      ash_pkg::ST_INIT0: begin
        edge_we = 1'b1;
        edge_wd = clampv(XW'(low_r));
        cnt_we  = 1'b1;
      end
      ash_pkg::ST_INIT1: begin
        edge_we = 1'b1;
        edge_wa = NW'(1);
        edge_wd = clampv(XW'(high_r));
      end
      ash_pkg::ST_INS_RN:   edge_ra = n_r;
      ash_pkg::ST_SRCH_ISS: edge_ra = mid;
      ash_pkg::ST_LO_RD:    edge_ra = NW'(1);
      ash_pkg::ST_HI_RD:    edge_ra = n_r - NW'(1);
      ash_pkg::ST_HI_WR: begin
        edge_we = 1'b1;
        edge_wa = n_r + NW'(1);
        edge_wd = clampv(XW'(s_r) + (XW'(en_r) - XW'(edge_rd)));
        cnt_we  = 1'b1;
        cnt_wa  = CAW'(n_r);
      end
      ash_pkg::ST_SHIFT: begin
        // move one entry up a place per cycle, top first
        if (sh_pend_r) begin
          edge_we = 1'b1;
          edge_wa = sh_prev_r + NW'(1);
          edge_wd = edge_rd;
          if (sh_prev_r < n_r) begin
            cnt_we = 1'b1;
            cnt_wa = CAW'(sh_prev_r + NW'(1));
            cnt_wd = cnt_rd;
          end
        end
        edge_ra = sh_i_r;
        cnt_ra  = CAW'(sh_i_r);
      end
      ash_pkg::ST_LO_WR: begin
        edge_we = 1'b1;
        edge_wd = nl_r;
        cnt_we  = 1'b1;
      end
      ash_pkg::ST_CNT_RD: begin
        edge_ra = pos_r;
        cnt_ra  = CAW'(pos_r);
      end
      ash_pkg::ST_CNT_RD1: edge_ra = pos_r + NW'(1);
      ash_pkg::ST_CNT_UPD: begin
        cnt_we = 1'b1;
        cnt_wa = CAW'(pos_r);
        cnt_wd = cnt_inc;
      end
      ash_pkg::ST_DIV_GO: div_start = 1'b1;
      ash_pkg::ST_SPL_WR0: begin
        edge_we = 1'b1;
        edge_wa = pos_r + NW'(1);
        edge_wd = mean;
        cnt_we  = 1'b1;
        cnt_wa  = CAW'(pos_r + NW'(1));
        cnt_wd  = up_c;
      end
      ash_pkg::ST_SPL_WR1: begin
        cnt_we = 1'b1;
        cnt_wa = CAW'(pos_r);
        cnt_wd = dn_c;
      end
      ash_pkg::ST_RB_RD: begin
        edge_ra = NW'(k_r);
        cnt_ra  = CAW'(k_r);
      end
      ash_pkg::ST_RB_RD1: edge_ra = NW'(k_r) + NW'(1);
      ash_pkg::ST_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = CAW'(clr_i_r);
      end
      ash_pkg::ST_COL_RD: edge_ra = n_r;
      ash_pkg::ST_COL_WR: begin
        edge_we = 1'b1;
        edge_wa = NW'(1);
        edge_wd = edge_rd;
        cnt_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ash_pkg::ST_INIT0;
      quiet_r     <= 1'b1;
      n_r         <= NW'(1);
      samples_r   <= '0;
      sh_pend_r   <= 1'b0;
      sh_fin_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result held while stalled, a new one loaded from the output state
      out_valid_r <= (out_valid_r && out_stall) || (state_r == ash_pkg::ST_OUT && out_free);
      case (state_r)
        ash_pkg::ST_INIT1: begin
          quiet_r   <= 1'b0;
          n_r       <= NW'(1);
          samples_r <= '0;
        end
        ash_pkg::ST_IDLE: begin
          if (accept) begin
            s_r      <= clampv(XW'(signed'(in_data.sample)));
            k_r      <= in_data.bar_index;
            status_r <= (in_data.func == ash_pkg::FN_READ && !rd_ok) ?
                        ash_pkg::STS_RANGE : ash_pkg::STS_OK;
            idx_r    <= (in_data.func == ash_pkg::FN_READ) ? in_data.bar_index : 6'd0;
            bs_r     <= '0;
            be_r     <= '0;
            cnt_r    <= '0;
            clr_i_r  <= '0;
            if (in_data.func == ash_pkg::FN_CLEAR) samples_r <= '0;
          end
        end
        ash_pkg::ST_INS_RN: e0_r <= edge_rd;
        ash_pkg::ST_INS_CHK: begin
          en_r <= edge_rd;
          a_r  <= '0;
          z_r  <= n_r;
          pos_r <= n_r;
          if ((lo_out || hi_out) && n_r == NW'(MAX_BINS)) status_r <= ash_pkg::STS_FULL;
        end
        ash_pkg::ST_SRCH_ISS: if (z_r - a_r <= NW'(1)) pos_r <= a_r;
        ash_pkg::ST_SRCH_CMP: begin
          if (s_r < edge_rd) z_r <= mid;
          else a_r <= mid;
        end
        ash_pkg::ST_LO_NL: begin
          nl_r      <= clampv(XW'(s_r) - (XW'(edge_rd) - XW'(e0_r)));
          grow_r    <= 1'b1;
          sh_i_r    <= n_r;
          sh_base_r <= '0;
          sh_pend_r <= 1'b0;
          sh_fin_r  <= 1'b0;
        end
        ash_pkg::ST_HI_WR: n_r <= n_r + NW'(1);
        ash_pkg::ST_SHIFT: begin
          if (sh_fin_r) begin
            sh_pend_r <= 1'b0;
            sh_fin_r  <= 1'b0;
          end else begin
            sh_pend_r <= 1'b1;
            sh_prev_r <= sh_i_r;
            if (sh_i_r == sh_base_r) sh_fin_r <= 1'b1;
            else sh_i_r <= sh_i_r - NW'(1);
          end
        end
        ash_pkg::ST_LO_WR: begin
          n_r   <= n_r + NW'(1);
          pos_r <= '0;
        end
        ash_pkg::ST_CNT_RD1: begin
          bs_r  <= edge_rd;
          cnt_r <= cnt_rd;
        end
        ash_pkg::ST_CNT_UPD: begin
          be_r  <= edge_rd;
          cnt_r <= cnt_inc;
          idx_r <= 6'(pos_r);
          if (samples_r != 32'hFFFF_FFFF) samples_r <= samples_r + 32'd1;
        end
        ash_pkg::ST_CNT_SQ: sq_r <= cnt_r * cnt_r;
        ash_pkg::ST_SPL_DEC: begin
          diff_r    <= width_x[DW-1:0];
          grow_r    <= 1'b0;
          sh_i_r    <= n_r;
          sh_base_r <= pos_r + NW'(1);
          sh_pend_r <= 1'b0;
          sh_fin_r  <= 1'b0;
        end
        // width times lower share, in two 32-bit slices
        ash_pkg::ST_MUL0: acc_r <= PW'(diff64[31:0] * dn_c);
        ash_pkg::ST_MUL1: acc_r <= acc_r + (PW'(diff64[63:32] * dn_c) << 32);
        ash_pkg::ST_SPL_WR1: n_r <= n_r + NW'(1);
        ash_pkg::ST_RB_RD1: begin
          bs_r  <= edge_rd;
          cnt_r <= cnt_rd;
        end
        ash_pkg::ST_RB_END: be_r <= edge_rd;
        ash_pkg::ST_CLR: clr_i_r <= clr_i_r + NW'(1);
        ash_pkg::ST_COL_WR: begin
          n_r       <= NW'(1);
          samples_r <= '0;
        end
        ash_pkg::ST_OUT: begin
          if (out_free) begin
            out_r.status       <= status_r;
            out_r.bin_index    <= idx_r;
            out_r.bar_start    <= to32(bs_r);
            out_r.bar_end      <= to32(be_r);
            out_r.bar_count    <= cnt_r;
            out_r.bar_total    <= 7'(n_r);
            out_r.sample_total <= samples_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`include "assert_macros.svh"

  // table never grows past its depth
  `ASH_IMPLIES(a_shift_room, state_r == ash_pkg::ST_SHIFT, n_r < NW'(MAX_BINS))
  // bins in use change by one step or fall back to a single bin
  `ASH_NEXT(a_n_step, 1'b1, n_r == $past(n_r) || n_r == $past(n_r) + NW'(1) || n_r == NW'(1))
  // an accepted insert always starts with the lower edge read
  `ASH_NEXT(a_ins_start, accept && in_data.func == ash_pkg::FN_INSERT,
            state_r == ash_pkg::ST_INS_R0)

endmodule
